/* rtl/lbps_pkg.sv */
// Shared types, constants and the raised cosine table for the LED pattern sequencer.
`timescale 1ns / 1ps
`default_nettype none

package lbps_pkg;

    // Sizing constants.
    localparam int COS_TABLE_BITS = 8;
    localparam int TIME_BITS      = 16;
    localparam int LEVEL_W        = 8;
    localparam int IDX_W          = 8;
    localparam int COS_DEPTH      = 256;
    localparam int MODE_W         = 3;
    localparam int FIELD_TIME_W   = 16;
    localparam int DIV_CNT_W      = (COS_TABLE_BITS > 1) ? $clog2(COS_TABLE_BITS) : 1;

    typedef logic [TIME_BITS-1:0]      t_time;
    typedef logic [LEVEL_W-1:0]        t_level;
    typedef logic [COS_TABLE_BITS-1:0] t_quo;
    typedef logic [DIV_CNT_W-1:0]      t_div_cnt;

    localparam t_time    TIME_MAX     = '1;
    localparam t_div_cnt DIV_LAST_CNT = DIV_CNT_W'(COS_TABLE_BITS - 1);

    // Item modes as they arrive on the input stream.
    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BLINK = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CONST = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OFF   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PULSE = 3'd4;

    // Activity codes reported on the output stream.
    localparam logic [2:0] ACT_IDLE  = 3'd0;
    localparam logic [2:0] ACT_ON    = 3'd1;
    localparam logic [2:0] ACT_OFF   = 3'd2;
    localparam logic [2:0] ACT_CONST = 3'd3;
    localparam logic [2:0] ACT_PULSE = 3'd4;

    // Default blink phase lengths in milliseconds, selected by blink count.
    localparam logic [FIELD_TIME_W-1:0] DEF_ON_ONE    = 16'd400;
    localparam logic [FIELD_TIME_W-1:0] DEF_OFF_ONE   = 16'd400;
    localparam logic [FIELD_TIME_W-1:0] DEF_ON_TWO    = 16'd100;
    localparam logic [FIELD_TIME_W-1:0] DEF_OFF_TWO   = 16'd300;
    localparam logic [FIELD_TIME_W-1:0] DEF_ON_THREE  = 16'd67;
    localparam logic [FIELD_TIME_W-1:0] DEF_OFF_THREE = 16'd200;
    localparam logic [FIELD_TIME_W-1:0] DEF_ON_MANY   = 16'd50;
    localparam logic [FIELD_TIME_W-1:0] DEF_OFF_MANY  = 16'd150;

    // One input item as unpacked from the stream.
    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        t_level                  brightness;
        logic [7:0]              blink_count;
        logic [FIELD_TIME_W-1:0] on_time;
        logic [FIELD_TIME_W-1:0] off_time;
        logic                    hold_last;
        logic [FIELD_TIME_W-1:0] period;
    } t_item;

    // A stored LED command (pending or active).
    typedef struct packed {
        logic [MODE_W-1:0] kind;
        t_level            bright;
        logic [7:0]        count;
        t_time             on_t;
        t_time             off_t;
        logic              hold;
        t_time             per;
    } t_cmd_rec;

    // Controller to datapath commands.
    typedef struct packed {
        logic take_item;
        logic div_step;
        logic mul_load;
        logic scale_load;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic pulse_calc;
        logic div_last;
    } t_dp_stat;

    // Raised cosine table, built at elaboration by the Q30 cosine recurrence.
    typedef logic [LEVEL_W-1:0] t_cos_tbl [COS_DEPTH];

    localparam longint Q30_ONE      = 64'sd1073741824;
    localparam longint Q29_ONE      = 64'sd536870912;
    localparam longint COS_STEP_Q30 = 64'sd1073418433;

    function automatic t_cos_tbl build_cos_table();
        longint   prev;
        longint   cur;
        longint   nxt;
        longint   u;
        longint   v;
        t_cos_tbl tbl;
        prev = COS_STEP_Q30;
        cur  = Q30_ONE;
        for (int k = 0; k < COS_DEPTH; k++) begin
            if (cur > Q30_ONE) begin
                cur = Q30_ONE;
            end
            if (cur < -Q30_ONE) begin
                cur = -Q30_ONE;
            end
            u = Q30_ONE - cur;
            v = (64'sd255 * u + Q30_ONE) >>> 31;
            if (v > 64'sd255) begin
                v = 64'sd255;
            end
            tbl[k] = v[LEVEL_W-1:0];
            nxt  = (COS_STEP_Q30 * cur) / Q29_ONE - prev;
            prev = cur;
            cur  = nxt;
        end
        return tbl;
    endfunction

    localparam t_cos_tbl COS_TABLE = build_cos_table();

    // Table index from the phase quotient: (q * 256) >> COS_TABLE_BITS.
    function automatic logic [IDX_W-1:0] cos_index(input t_quo q);
        logic [COS_TABLE_BITS+IDX_W-1:0] t;
        t = {q, IDX_W'(0)} >> COS_TABLE_BITS;
        return t[IDX_W-1:0];
    endfunction

    // Exact x / 255 for any 16-bit product of two 8-bit levels.
    function automatic t_level div255(input logic [2*LEVEL_W-1:0] x);
        logic [2*LEVEL_W:0] s;
        s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

`default_nettype wire

/* rtl/lbps_ctrl.sv */
// Sequencing controller: handshakes, pulse divide steps and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module lbps_ctrl (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output lbps_pkg::t_dp_cmd        o_cmd,
    input  wire lbps_pkg::t_dp_stat  i_stat
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_MUL   = 5'b00100,
        S_SCALE = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_fire;
    logic   emit_ok;

    assign in_fire = (r_state == S_IDLE) && i_in_valid;
    assign emit_ok = !r_out_valid || i_out_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_in_ready       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state = i_stat.pulse_calc ? S_DIV : S_EMIT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale_load = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (emit_ok) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid flag: set by a new result, cleared when a transaction takes it.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // An item that needs no pulse math is ready to hand off in the next cycle.
    a_short_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_stat.pulse_calc) |=> (r_state == S_EMIT))
        else $error("short item did not reach hand-off");

    // A pulse tick goes through the divider.
    a_pulse_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_stat.pulse_calc) |=> (r_state == S_DIV))
        else $error("pulse tick skipped the divider");

    // The last divide step leads straight into the table lookup and scaling.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_stat.div_last) |=> (r_state == S_MUL) ##1 (r_state == S_SCALE))
        else $error("divider finish sequence broken");

    // A new result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before its transaction");

endmodule

`default_nettype wire

/* rtl/lbps_dp.sv */
// Datapath: pending and active commands, blink timing, pulse phase divider and scaling.
`timescale 1ns / 1ps
`default_nettype none

module lbps_dp (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire lbps_pkg::t_dp_cmd   i_cmd,
    output lbps_pkg::t_dp_stat       o_stat,
    input  wire lbps_pkg::t_item     i_item,
    input  wire [7:0]                i_ambient,
    output logic [7:0]               o_level,
    output logic [2:0]               o_activity,
    output logic                     o_pending
);

    // Sequencer state.
    logic [2:0]         r_act,       n_act;
    logic               r_pend_valid, n_pend_valid;
    lbps_pkg::t_cmd_rec r_pending,   n_pending;
    lbps_pkg::t_cmd_rec r_active,    n_active;
    logic [7:0]         r_blink_idx, n_blink_idx;
    lbps_pkg::t_time    r_elapsed,   n_elapsed;
    lbps_pkg::t_level   r_level,     n_level;

    // Pulse arithmetic.
    lbps_pkg::t_time    r_rem;
    lbps_pkg::t_quo     r_quo;
    lbps_pkg::t_div_cnt r_div_cnt;
    logic [15:0]        r_prod;

    logic                                 is_tick;
    logic                                 is_cmd;
    lbps_pkg::t_cmd_rec                   item_rec;
    logic [lbps_pkg::FIELD_TIME_W-1:0]    def_on;
    logic [lbps_pkg::FIELD_TIME_W-1:0]    def_off;
    lbps_pkg::t_time                      el_inc;
    logic [lbps_pkg::TIME_BITS:0]         el_wrap;
    logic                                 hold_end;
    logic                                 more_blinks;
    logic [lbps_pkg::TIME_BITS:0]         rem_dbl;
    logic                                 rem_ge;
    logic [lbps_pkg::TIME_BITS:0]         rem_sub;

    assign is_tick = (i_item.mode == lbps_pkg::MODE_TICK);
    assign is_cmd  = (i_item.mode == lbps_pkg::MODE_BLINK) || (i_item.mode == lbps_pkg::MODE_CONST)
                  || (i_item.mode == lbps_pkg::MODE_OFF)   || (i_item.mode == lbps_pkg::MODE_PULSE);

    // Default blink times by count.
    always_comb begin
        case (i_item.blink_count)
            8'd1: begin
                def_on  = lbps_pkg::DEF_ON_ONE;
                def_off = lbps_pkg::DEF_OFF_ONE;
            end
            8'd2: begin
                def_on  = lbps_pkg::DEF_ON_TWO;
                def_off = lbps_pkg::DEF_OFF_TWO;
            end
            8'd3: begin
                def_on  = lbps_pkg::DEF_ON_THREE;
                def_off = lbps_pkg::DEF_OFF_THREE;
            end
            default: begin
                def_on  = lbps_pkg::DEF_ON_MANY;
                def_off = lbps_pkg::DEF_OFF_MANY;
            end
        endcase
    end

    // Build the command record from an incoming command item.
    always_comb begin
        item_rec      = '0;
        item_rec.kind = i_item.mode;
        if (i_item.mode != lbps_pkg::MODE_OFF) begin
            item_rec.bright = i_item.brightness;
        end
        if (i_item.mode == lbps_pkg::MODE_BLINK) begin
            item_rec.count = i_item.blink_count;
            item_rec.on_t  = lbps_pkg::t_time'((i_item.on_time == '0) ? def_on : i_item.on_time);
            item_rec.off_t = lbps_pkg::t_time'((i_item.off_time == '0) ? def_off : i_item.off_time);
            item_rec.hold  = i_item.hold_last;
        end
        if (i_item.mode == lbps_pkg::MODE_PULSE) begin
            item_rec.per = lbps_pkg::t_time'(i_item.period);
        end
    end

    // Timer helpers: saturating count for blink phases, wrap at period for pulse.
    assign el_inc   = (r_elapsed == lbps_pkg::TIME_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign el_wrap  = {1'b0, r_elapsed} + 1'b1;
    assign hold_end = r_active.hold && (r_active.count != 8'd0)
                   && (r_blink_idx == r_active.count - 8'd1);
    assign more_blinks = ({1'b0, r_blink_idx} + 9'd1) < {1'b0, r_active.count};

    assign o_stat.pulse_calc = is_tick && (r_act == lbps_pkg::ACT_PULSE)
                            && (r_active.per != '0) && !r_pend_valid;
    assign o_stat.div_last   = (r_div_cnt == lbps_pkg::DIV_LAST_CNT);

    // State update for one accepted item, and the load of the scaled pulse level.
    always_comb begin
        n_act        = r_act;
        n_pend_valid = r_pend_valid;
        n_pending    = r_pending;
        n_active     = r_active;
        n_blink_idx  = r_blink_idx;
        n_elapsed    = r_elapsed;
        n_level      = r_level;
        if (i_cmd.take_item && is_cmd) begin
            n_pending    = item_rec;
            n_pend_valid = 1'b1;
        end else if (i_cmd.take_item && is_tick) begin
            unique case (r_act)
                lbps_pkg::ACT_IDLE: begin
                    if (r_pend_valid) begin
                        n_active     = r_pending;
                        n_pend_valid = 1'b0;
                        n_blink_idx  = 8'd0;
                        n_elapsed    = '0;
                        case (r_pending.kind)
                            lbps_pkg::MODE_BLINK: begin
                                n_act   = lbps_pkg::ACT_ON;
                                n_level = r_pending.bright;
                            end
                            lbps_pkg::MODE_CONST: begin
                                n_act   = lbps_pkg::ACT_CONST;
                                n_level = r_pending.bright;
                            end
                            lbps_pkg::MODE_PULSE: begin
                                n_act = lbps_pkg::ACT_PULSE;
                            end
                            default: begin
                                n_act   = lbps_pkg::ACT_IDLE;
                                n_level = i_ambient;
                            end
                        endcase
                    end
                end
                lbps_pkg::ACT_ON: begin
                    n_elapsed = el_inc;
                    if (el_inc >= r_active.on_t) begin
                        n_level = i_ambient;
                        if (hold_end) begin
                            n_act = lbps_pkg::ACT_IDLE;
                        end else begin
                            n_act     = lbps_pkg::ACT_OFF;
                            n_elapsed = '0;
                        end
                    end
                end
                lbps_pkg::ACT_OFF: begin
                    n_elapsed = el_inc;
                    if (el_inc >= r_active.off_t) begin
                        if (more_blinks) begin
                            n_blink_idx = r_blink_idx + 8'd1;
                            n_act       = lbps_pkg::ACT_ON;
                            n_level     = r_active.bright;
                            n_elapsed   = '0;
                        end else begin
                            n_act   = lbps_pkg::ACT_IDLE;
                            n_level = i_ambient;
                        end
                    end
                end
                lbps_pkg::ACT_CONST: begin
                    if (r_pend_valid) begin
                        n_act   = lbps_pkg::ACT_IDLE;
                        n_level = i_ambient;
                    end
                end
                lbps_pkg::ACT_PULSE: begin
                    // Nonzero period and no waiting command: the level itself comes later from the divider.
                    if (r_active.per == '0) begin
                        n_elapsed = '0;
                        n_level   = '0;
                    end else if (el_wrap == {1'b0, r_active.per}) begin
                        n_elapsed = '0;
                    end else begin
                        n_elapsed = el_wrap[lbps_pkg::TIME_BITS-1:0];
                    end
                    if (r_pend_valid) begin
                        n_act   = lbps_pkg::ACT_IDLE;
                        n_level = i_ambient;
                    end
                end
                default: begin
                    n_act   = lbps_pkg::ACT_IDLE;
                    n_level = i_ambient;
                end
            endcase
        end else if (i_cmd.scale_load) begin
            n_level = lbps_pkg::div255(r_prod);
        end
    end

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act        <= lbps_pkg::ACT_IDLE;
            r_pend_valid <= 1'b0;
            r_blink_idx  <= 8'd0;
            r_elapsed    <= '0;
            r_level      <= '0;
            r_div_cnt    <= '0;
        end else begin
            r_act        <= n_act;
            r_pend_valid <= n_pend_valid;
            r_blink_idx  <= n_blink_idx;
            r_elapsed    <= n_elapsed;
            r_level      <= n_level;
            if (i_cmd.take_item) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 1'b1;
            end
        end
    end

    // Restoring divider step: one quotient bit of (phase << COS_TABLE_BITS) / period.
    assign rem_dbl = {r_rem, 1'b0};
    assign rem_ge  = rem_dbl >= {1'b0, r_active.per};
    assign rem_sub = rem_dbl - {1'b0, r_active.per};

    // Payload registers: stored commands and pulse arithmetic.
    always_ff @(posedge i_clk) begin
        r_pending <= n_pending;
        r_active  <= n_active;
        if (i_cmd.take_item) begin
            r_rem <= n_elapsed;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_sub[lbps_pkg::TIME_BITS-1:0] : rem_dbl[lbps_pkg::TIME_BITS-1:0];
            r_quo <= {r_quo[lbps_pkg::COS_TABLE_BITS-2:0], rem_ge};
        end
        if (i_cmd.mul_load) begin
            r_prod <= r_active.bright * lbps_pkg::COS_TABLE[lbps_pkg::cos_index(r_quo)];
        end
    end

    assign o_level    = r_level;
    assign o_activity = r_act;
    assign o_pending  = r_pend_valid;

endmodule

`default_nettype wire

/* rtl/led_blink_pulse_sequencer_unit.sv */
// Top level of the LED pattern sequencer: stream ports, ambient register, result register.
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         s_axis_tvalid/s_axis_tready    one tick or command item
//  m_axis    out        m_axis_tvalid/m_axis_tready    LED state after that item
//  cfg       in         i_cfg_valid/o_cfg_ready        ambient level
//
// Every input item gives exactly one result. A pulse tick with a nonzero period and no
// waiting command goes through the phase divider (one quotient bit per cycle), the table
// lookup and the scaling step (S_DIV, S_MUL, S_SCALE) before hand-off in S_EMIT; every
// other item goes from acceptance straight to hand-off.
// Reset is synchronous; the cosine table is constant, so no clearing pass follows reset.
// While a result waits on m_axis the next item is still accepted; its own result
// then waits in the controller until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module led_blink_pulse_sequencer_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [71:0] s_axis_tdata,   // brightness, blink_count, on_time, off_time,
                                        // hold_last, period, zero fill
    input  wire  [2:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // led_level, command_pending, zero fill
    output logic [2:0]  m_axis_tuser,   // activity
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [7:0]  i_cfg_data      // ambient_level
);

    lbps_pkg::t_dp_cmd  dp_cmd;
    lbps_pkg::t_dp_stat dp_stat;
    lbps_pkg::t_item    item;
    logic [7:0]         dp_level;
    logic [2:0]         dp_act;
    logic               dp_pend;

    logic [7:0]         r_ambient;
    logic [7:0]         r_out_level;
    logic [2:0]         r_out_act;
    logic               r_out_pend;

    // Unpack the input transaction.
    always_comb begin
        item.mode        = s_axis_tuser;
        item.brightness  = s_axis_tdata[7:0];
        item.blink_count = s_axis_tdata[15:8];
        item.on_time     = s_axis_tdata[31:16];
        item.off_time    = s_axis_tdata[47:32];
        item.hold_last   = s_axis_tdata[48];
        item.period      = s_axis_tdata[64:49];
    end

    // Ambient level register; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ambient <= 8'd0;
        end else if (i_cfg_valid) begin
            r_ambient <= i_cfg_data;
        end
    end

    lbps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    lbps_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .i_item     (item),
        .i_ambient  (r_ambient),
        .o_level    (dp_level),
        .o_activity (dp_act),
        .o_pending  (dp_pend)
    );

    // Result register, loaded when the controller hands off a finished item.
    always_ff @(posedge i_clk) begin
        if (dp_cmd.emit) begin
            r_out_level <= dp_level;
            r_out_act   <= dp_act;
            r_out_pend  <= dp_pend;
        end
    end

    assign m_axis_tdata = {7'd0, r_out_pend, r_out_level};
    assign m_axis_tuser = r_out_act;

endmodule

`default_nettype wire

/* sim/led_blink_pulse_sequencer_unit_test.sv */
// Self-checking stream testbench for the LED blink and pulse sequencer.
`timescale 1ns / 1ps

module led_blink_pulse_sequencer_unit_test;

    import lbps_pkg::*;

    localparam int CYCLE_LIMIT  = 4000000;
    localparam int RANDOM_ITEMS = 600;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 20;

    // Expected contents of one result transaction.
    typedef struct {
        logic [7:0] level;
        logic [2:0] activity;
        logic       pending;
    } led_state_t;

    // Tracks the LED controller state and queues the state expected after each item.
    class led_state_scoreboard;
        led_state_t expected_led_states[$];
        int unsigned errors;
        logic [7:0]  ambient;
        logic [2:0]  activity;
        logic        cmd_waiting;
        t_cmd_rec    waiting_cmd;
        t_cmd_rec    running_cmd;
        logic [7:0]  blink_num;
        logic [15:0] elapsed;
        logic [7:0]  level;
        logic [7:0]  cos_lut [256];

        function new();
            longint one;
            longint step;
            longint prv;
            longint cur;
            longint nxt;
            longint u;
            longint v;
            errors      = 0;
            ambient     = '0;
            activity    = ACT_IDLE;
            cmd_waiting = 1'b0;
            waiting_cmd = '0;
            running_cmd = '0;
            blink_num   = '0;
            elapsed     = '0;
            level       = '0;
            // Raised cosine levels from the Q30 cosine recurrence.
            one  = 64'sd1073741824;
            step = 64'sd1073418433;
            prv  = step;
            cur  = one;
            for (int k = 0; k < 256; k++) begin
                if (cur > one) begin
                    cur = one;
                end
                if (cur < -one) begin
                    cur = -one;
                end
                u = one - cur;
                v = (64'sd255 * u + one) >>> 31;
                cos_lut[k] = (v > 64'sd255) ? 8'd255 : v[7:0];
                nxt = (step * cur) / (one / 2) - prv;
                prv = cur;
                cur = nxt;
            end
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH %s", $time, msg);
            errors++;
        endtask

        function void set_ambient(logic [7:0] value);
            ambient = value;
        endfunction

        function int outstanding();
            return expected_led_states.size();
        endfunction

        // True while a blink runs or a command is about to be taken.
        function bit busy();
            return (activity == ACT_ON) || (activity == ACT_OFF) || cmd_waiting;
        endfunction

        function void enter_idle();
            activity = ACT_IDLE;
            level    = ambient;
        endfunction

        function logic [7:0] pulse_level();
            longint q;
            int     prod;
            if (running_cmd.per == '0) begin
                return 8'd0;
            end
            q    = (longint'(elapsed) << 8) / longint'(running_cmd.per);
            prod = int'(running_cmd.bright) * int'(cos_lut[q[7:0]]);
            return 8'(prod / 255);
        endfunction

        // One millisecond of controller time.
        function void advance();
            int last;
            last = int'(running_cmd.count) - 1;
            case (activity)
                ACT_IDLE: begin
                    if (cmd_waiting) begin
                        running_cmd = waiting_cmd;
                        cmd_waiting = 1'b0;
                        blink_num   = '0;
                        elapsed     = '0;
                        if (running_cmd.kind == MODE_BLINK) begin
                            activity = ACT_ON;
                            level    = running_cmd.bright;
                        end else if (running_cmd.kind == MODE_CONST) begin
                            activity = ACT_CONST;
                            level    = running_cmd.bright;
                        end else if (running_cmd.kind == MODE_PULSE) begin
                            activity = ACT_PULSE;
                        end else begin
                            enter_idle();
                        end
                    end
                end
                ACT_ON: begin
                    if (elapsed != 16'hFFFF) begin
                        elapsed++;
                    end
                    if (elapsed >= running_cmd.on_t) begin
                        if (running_cmd.hold && int'(blink_num) == last) begin
                            enter_idle();
                        end else begin
                            activity = ACT_OFF;
                            level    = ambient;
                            elapsed  = '0;
                        end
                    end
                end
                ACT_OFF: begin
                    if (elapsed != 16'hFFFF) begin
                        elapsed++;
                    end
                    if (elapsed >= running_cmd.off_t) begin
                        if (int'(blink_num) < last) begin
                            blink_num++;
                            activity = ACT_ON;
                            level    = running_cmd.bright;
                            elapsed  = '0;
                        end else begin
                            enter_idle();
                        end
                    end
                end
                ACT_CONST: begin
                    if (cmd_waiting) begin
                        enter_idle();
                    end
                end
                ACT_PULSE: begin
                    if (running_cmd.per == '0) begin
                        elapsed = '0;
                    end else begin
                        elapsed = 16'((int'(elapsed) + 1) % int'(running_cmd.per));
                    end
                    level = pulse_level();
                    if (cmd_waiting) begin
                        enter_idle();
                    end
                end
                default: enter_idle();
            endcase
        endfunction

        // Applies one accepted input item and queues the resulting LED state.
        function void predict_led_state(t_item it);
            t_cmd_rec   c;
            led_state_t s;
            if (it.mode == MODE_TICK) begin
                advance();
            end else if (it.mode <= MODE_PULSE) begin
                c      = '0;
                c.kind = it.mode;
                if (it.mode != MODE_OFF) begin
                    c.bright = it.brightness;
                end
                if (it.mode == MODE_BLINK) begin
                    c.count = it.blink_count;
                    c.on_t  = it.on_time;
                    c.off_t = it.off_time;
                    c.hold  = it.hold_last;
                    // Zero phase lengths pick defaults by blink count.
                    if (c.on_t == '0) begin
                        c.on_t = (c.count == 8'd1) ? DEF_ON_ONE :
                                 (c.count == 8'd2) ? DEF_ON_TWO :
                                 (c.count == 8'd3) ? DEF_ON_THREE : DEF_ON_MANY;
                    end
                    if (c.off_t == '0) begin
                        c.off_t = (c.count == 8'd1) ? DEF_OFF_ONE :
                                  (c.count == 8'd2) ? DEF_OFF_TWO :
                                  (c.count == 8'd3) ? DEF_OFF_THREE : DEF_OFF_MANY;
                    end
                end
                if (it.mode == MODE_PULSE) begin
                    c.per = it.period;
                end
                waiting_cmd = c;
                cmd_waiting = 1'b1;
            end
            s.level    = level;
            s.activity = activity;
            s.pending  = cmd_waiting;
            expected_led_states.push_back(s);
        endfunction

        // Compares one result transaction with the oldest expected state.
        task check_led_state(logic [7:0] lvl, logic [2:0] act, logic pend);
            led_state_t s;
            if (expected_led_states.size() == 0) begin
                report($sformatf("result with nothing expected: level %0d activity %0d",
                                 lvl, act));
            end else begin
                s = expected_led_states.pop_front();
                if (lvl !== s.level) begin
                    report($sformatf("led_level got %0d expected %0d", lvl, s.level));
                end
                if (act !== s.activity) begin
                    report($sformatf("activity got %0d expected %0d", act, s.activity));
                end
                if (pend !== s.pending) begin
                    report($sformatf("command_pending got %0d expected %0d",
                                     pend, s.pending));
                end
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    led_state_scoreboard sb;
    int  in_gap_max;
    int  out_gap_max;
    bit  stall_request;
    int  items_accepted;
    int  cycle_count;

    led_blink_pulse_sequencer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit; a hung handshake ends here.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int draw_gap(int limit_cycles);
        return (limit_cycles == 0) ? 0 : int'($urandom_range(0, limit_cycles));
    endfunction

    function automatic logic [7:0] rand_level();
        int unsigned r;
        r = $urandom_range(0, 7);
        return (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 255));
    endfunction

    function automatic t_item make_item(logic [2:0] mode, logic [7:0] bright,
                                        logic [7:0] count, logic [15:0] on_t,
                                        logic [15:0] off_t, logic hold, logic [15:0] per);
        t_item it;
        it.mode        = mode;
        it.brightness  = bright;
        it.blink_count = count;
        it.on_time     = on_t;
        it.off_time    = off_t;
        it.hold_last   = hold;
        it.period      = per;
        return it;
    endfunction

    function automatic t_item random_fields(logic [2:0] mode);
        return make_item(mode, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
    endfunction

    // Command of the given kind, with blinks short enough to finish.
    function automatic t_item random_command(logic [2:0] kind);
        t_item       it;
        int unsigned r;
        it            = random_fields(kind);
        it.brightness = rand_level();
        if (kind == MODE_BLINK) begin
            r = $urandom_range(0, 15);
            if (r == 0) begin
                it.blink_count = 8'($urandom_range(0, 255));
                it.on_time     = 16'($urandom_range(1, 2));
                it.off_time    = 16'($urandom_range(1, 2));
            end else begin
                it.blink_count = 8'($urandom_range(0, 5));
                it.on_time     = 16'($urandom_range(1, 6));
                it.off_time    = 16'($urandom_range(1, 6));
                // Now and then one phase falls back to its default length.
                if (r == 1) begin
                    it.blink_count = 8'($urandom_range(0, 3));
                    if ($urandom_range(0, 1) == 0) begin
                        it.on_time = '0;
                    end else begin
                        it.off_time = '0;
                    end
                end
            end
        end else if (kind == MODE_PULSE) begin
            r = $urandom_range(0, 7);
            it.period = (r == 0) ? 16'd0 :
                        (r == 1) ? 16'($urandom_range(0, 65535)) :
                                   16'($urandom_range(1, 40));
        end
        return it;
    endfunction

    function automatic logic [2:0] random_kind();
        int unsigned r;
        r = $urandom_range(0, 9);
        return (r < 4) ? MODE_BLINK : (r < 6) ? MODE_CONST : (r == 6) ? MODE_OFF : MODE_PULSE;
    endfunction

    // Offers one item and returns at the falling edge after its transaction.
    task automatic send_item(t_item it);
        int gap;
        gap = draw_gap(in_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, it.period, it.hold_last, it.off_time, it.on_time,
                          it.blink_count, it.brightness};
        s_axis_tuser  <= it.mode;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.predict_led_state(it);
        if (it.mode <= MODE_PULSE) begin
            items_accepted++;
        end
        @(negedge i_clk);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_item(random_fields(MODE_TICK));
    endtask

    task automatic tick_until_settled();
        while (sb.busy()) begin
            send_item(random_fields(MODE_TICK));
        end
    endtask

    // Stops offering items until every expected result has arrived.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_ambient(logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_ambient(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // A command, maybe preceded by an unused-mode item and by one it overwrites, followed by ticks.
    task automatic run_random_episode();
        logic [2:0] kind;
        if ($urandom_range(0, 9) == 0) begin
            send_item(random_fields(3'($urandom_range(5, 7))));
        end
        kind = random_kind();
        if ($urandom_range(0, 3) == 0) begin
            send_item(random_command(random_kind()));
        end
        send_item(random_command(kind));
        if (kind == MODE_BLINK) begin
            // Commands arriving during a blink only replace the pending one.
            while (sb.busy()) begin
                if ($urandom_range(0, 15) == 0) begin
                    send_item(random_command(random_kind()));
                end else begin
                    send_item(random_fields(MODE_TICK));
                end
            end
            send_ticks($urandom_range(0, 3));
        end else begin
            send_ticks($urandom_range(1, (kind == MODE_PULSE) ? 30 : 8));
        end
    endtask

    // Result side: random back-pressure, one long hold-off on request.
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (stall_request) begin
                stall_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            gap = draw_gap(out_gap_max);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_led_state(m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[8]);
            @(negedge i_clk);
        end
    end

    initial begin
        int next_cfg_at;
        int random_start;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        i_rst_n        = 1'b0;
        in_gap_max     = 15;
        out_gap_max    = 15;
        stall_request  = 1'b0;
        items_accepted = 0;
        sb = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Ambient set after reset does not show until idle is entered again.
        write_ambient(8'hA5);
        send_item(make_item(MODE_TICK, '1, '1, '1, '1, 1'b1, '1));
        for (int m = 5; m < 8; m++) begin
            send_item(make_item(3'(m), '1, '1, '1, '1, 1'b1, '1));
        end
        send_item(make_item(MODE_OFF, '1, '1, '1, '1, 1'b1, '1));
        send_ticks(1);

        // Constant on at both level extremes.
        send_item(make_item(MODE_CONST, 8'd255, '0, '0, '0, 1'b0, '0));
        send_ticks(2);
        send_item(make_item(MODE_CONST, 8'd0, '1, '1, '1, 1'b1, '1));
        send_ticks(2);

        // Pulse with zero, unit, short and longest periods.
        send_item(make_item(MODE_PULSE, 8'd255, '0, '0, '0, 1'b0, 16'd0));
        send_ticks(3);
        send_item(make_item(MODE_PULSE, 8'd255, '0, '0, '0, 1'b0, 16'd1));
        send_ticks(3);
        send_item(make_item(MODE_PULSE, 8'd255, '0, '0, '0, 1'b0, 16'd7));
        send_ticks(10);
        send_item(make_item(MODE_PULSE, 8'd200, '0, '0, '0, 1'b0, 16'hFFFF));
        send_ticks(4);

        // Blink count zero shows one blink and ignores hold_last.
        send_item(make_item(MODE_BLINK, 8'd9, 8'd0, 16'd2, 16'd3, 1'b1, '0));
        tick_until_settled();

        // A command during a held blink waits until the blink ends.
        send_item(make_item(MODE_BLINK, 8'd40, 8'd3, 16'd1, 16'd2, 1'b1, '0));
        send_ticks(2);
        send_item(make_item(MODE_CONST, 8'd77, '0, '0, '0, 1'b0, '0));
        tick_until_settled();
        send_ticks(1);
        send_item(make_item(MODE_OFF, '0, '0, '0, '0, 1'b0, '0));
        tick_until_settled();

        // Largest blink count.
        send_item(make_item(MODE_BLINK, 8'd255, 8'd255, 16'd1, 16'd1, 1'b0, '0));
        tick_until_settled();

        // Default phase lengths for each count class.
        for (int k = 0; k < 4; k++) begin
            send_item(make_item(MODE_BLINK, rand_level(), (k == 3) ? 8'd0 : 8'(k + 1),
                                16'd0, 16'd0, 1'b0, '0));
            tick_until_settled();
        end

        // Held blink, run without idling on either side.
        drain();
        repeat (SETTLE) @(negedge i_clk);
        write_ambient(8'd255);
        in_gap_max  = 0;
        out_gap_max = 0;
        send_item(make_item(MODE_BLINK, 8'd1, 8'd2, 16'd3, 16'd2, 1'b1, '0));
        tick_until_settled();
        send_ticks(2);
        in_gap_max  = 15;
        out_gap_max = 15;

        // Random episodes, with ambient rewritten between phases.
        stall_request = 1'b1;
        random_start  = items_accepted;
        next_cfg_at   = random_start + 150;
        while (items_accepted - random_start < RANDOM_ITEMS) begin
            if (items_accepted >= next_cfg_at) begin
                drain();
                repeat (SETTLE) @(negedge i_clk);
                case ($urandom_range(0, 2))
                    0: write_ambient(8'd0);
                    1: write_ambient(8'd255);
                    default: write_ambient(8'($urandom_range(0, 255)));
                endcase
                next_cfg_at += 150;
            end
            in_gap_max  = ($urandom_range(0, 7) == 0) ? 0 : 15;
            out_gap_max = ($urandom_range(0, 7) == 0) ? 0 : 15;
            run_random_episode();
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
